// ----- src/rbd_pkg.sv -----
package rbd_pkg;

    // Store geometry. Index and count widths follow from the depth.
    localparam int DEPTH  = 128;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int OCC_W  = 8;
    localparam int REQ_W  = 3;
    localparam int ST_W   = 2;

    // Request codes as they arrive on req_type.
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd4;
    localparam logic [REQ_W-1:0] REQ_STATUS     = 3'd5;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_RESP
    } state_t;

    // Operation the datapath carries out in the execute cycle.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        logic capture;
        op_t  op;
        logic lookup;
    } rbd_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rbd_stat_t;

endpackage

// ----- src/rbd_ctrl.sv -----
module rbd_ctrl
    import rbd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [REQ_W-1:0] req_type,
    input  rbd_stat_t        dp_stat,
    output rbd_cmd_t         cmd,
    output logic             busy,
    output logic             done,
    output status_t          status
);

    state_t           state_reg, state_next;
    logic [REQ_W-1:0] req_reg, req_next;
    status_t          status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            req_reg    <= REQ_STATUS;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            req_reg    <= req_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        status_next = status_reg;
        cmd         = '{capture: 1'b0, op: OP_NONE, lookup: 1'b0};
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    req_next    = req_type;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next = ST_OK;
                unique case (req_reg)
                    REQ_PUSH_FRONT:
                    begin
                        if (dp_stat.full)
                            status_next = ST_OVERFLOW;
                        else
                            cmd.op = OP_PUSH_FRONT;
                    end
                    REQ_PUSH_BACK:
                    begin
                        if (dp_stat.full)
                            status_next = ST_OVERFLOW;
                        else
                            cmd.op = OP_PUSH_BACK;
                    end
                    REQ_POP_FRONT:
                    begin
                        if (dp_stat.empty)
                            status_next = ST_UNDERFLOW;
                        else
                            cmd.op = OP_POP_FRONT;
                    end
                    REQ_POP_BACK:
                    begin
                        if (dp_stat.empty)
                            status_next = ST_UNDERFLOW;
                        else
                            cmd.op = OP_POP_BACK;
                    end
                    REQ_CLEAR:
                    begin
                        cmd.op = OP_CLEAR;
                    end
                    default:
                    begin
                        cmd.op = OP_NONE;
                    end
                endcase
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.lookup = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_RESP);
    assign status = status_reg;

endmodule

// ----- src/rbd_datapath.sv -----
module rbd_datapath
    import rbd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  rbd_cmd_t                 cmd,
    input  logic signed [WORD_W-1:0] push_value,
    output rbd_stat_t                dp_stat,
    output logic signed [WORD_W-1:0] front_word,
    output logic signed [WORD_W-1:0] back_word,
    output logic [OCC_W-1:0]         occupancy,
    output logic                     is_empty
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WORD_W-1:0] mem [DEPTH];

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] rd_front_reg, rd_back_reg;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  head_inc, head_dec, tail_inc, tail_dec;
    logic              cnt_zero;

    assign cnt_zero = (count_reg == '0);
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - 1'b1;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        case (cmd.op) inside
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                wr_en      = 1'b1;
                count_next = count_reg + 1'b1;
                if (cnt_zero)
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                else if (cmd.op == OP_PUSH_FRONT)
                begin
                    head_next = head_dec;
                    wr_addr   = head_dec;
                end
                else
                begin
                    tail_next = tail_inc;
                    wr_addr   = tail_inc;
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                count_next = count_reg - 1'b1;
                if (count_reg == CNT_W'(1))
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                else if (cmd.op == OP_POP_FRONT)
                    head_next = head_inc;
                else
                    tail_next = tail_dec;
            end
            OP_CLEAR:
            begin
                count_next = '0;
                head_next  = '0;
                tail_next  = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            word_reg <= push_value;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= word_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            rd_front_reg <= mem[head_reg];
            rd_back_reg  <= mem[tail_reg];
        end
    end

    assign dp_stat.full  = (count_reg == FULL_CNT);
    assign dp_stat.empty = cnt_zero;

    assign front_word = cnt_zero ? '1 : rd_front_reg;
    assign back_word  = cnt_zero ? '1 : rd_back_reg;
    assign occupancy  = OCC_W'(count_reg);
    assign is_empty   = cnt_zero;

endmodule

// ----- src/ring_buffer_deque_core.sv -----
// A request beat taken with start high and busy low passes through the EXEC, READ and
// RESP states and returns its result beat, marked by done; busy stays high meanwhile.
// A new request waits until the last one is done: the store's write is followed by
// its registered two-port read of the front and back entries.
// Reset (rst_n low, asynchronous) empties the deque; the store itself is not cleared.
// The receiver cannot stall: done marks each result for exactly one cycle.
module ring_buffer_deque_core
    import rbd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [REQ_W-1:0]         req_type,
    input  logic signed [WORD_W-1:0] push_value,
    output logic                     done,
    output logic signed [WORD_W-1:0] front_word,
    output logic signed [WORD_W-1:0] back_word,
    output logic [OCC_W-1:0]         occupancy,
    output logic                     is_empty,
    output logic [ST_W-1:0]          status
);

    // The controller sequences each request through execute, lookup and
    // response cycles and decides overflow or underflow from the datapath's
    // full and empty flags. The datapath holds the pointers, the count and
    // the circular store.
    rbd_cmd_t  cmd;
    rbd_stat_t dp_stat;
    status_t   status_code;

    rbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .dp_stat  (dp_stat),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done),
        .status   (status_code)
    );

    rbd_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_value (push_value),
        .dp_stat    (dp_stat),
        .front_word (front_word),
        .back_word  (back_word),
        .occupancy  (occupancy),
        .is_empty   (is_empty)
    );

    assign status = status_code;

    // An accepted request always makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request beat accepted but block not busy");

    // A result beat appears only while the request is still in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat outside a busy window");

    // An overflow is reported only when the deque holds its full depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_OVERFLOW) |-> occupancy == OCC_W'(DEPTH))
        else $error("overflow reported on a deque that is not full");

    // An underflow is reported only on an empty deque with both words at -1.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_UNDERFLOW) |-> is_empty && (front_word == -1)
            && (back_word == -1))
        else $error("underflow reported on a deque that is not empty");

endmodule
